### rtl/assert_macros.svh
// Assertion helpers; the using scope provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IDSA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IDSA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/idsa_pkg.sv
package idsa_pkg;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_INIT  = 2'd3
  } idsa_req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_DONE
  } idsa_state_e;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  // Slots 0 and 1 hold the two dot entries.
  localparam int unsigned DOT_SLOTS = 2;

  // Bitmap bits handled per cycle.
  localparam int unsigned WORD_BITS = 8;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef struct packed {
    idsa_req_e   req_type;
    logic [7:0]  name_length;
    logic [7:0]  slot_position;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  granted_slot;
    logic        dir_empty;
  } rsp_t;

  typedef struct packed {
    idsa_req_e   req;
    logic [7:0]  need;
    logic [7:0]  posn;
  } cmd_t;

endpackage

### rtl/idsa_stream_if.sv
interface idsa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/idsa_front.sv
module idsa_front #(
  parameter int unsigned SLOT_BYTES = 8
) (
  idsa_stream_if.sink       req_i,
  output logic              cmd_valid_o,
  output idsa_pkg::cmd_t    cmd_o,
  input  logic              cmd_ready_i
);
  import idsa_pkg::*;

  // Slot count is ceil(len / SLOT_BYTES): multiply by a rounded-up reciprocal.
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP = ((2 ** RECIP_SHIFT) + SLOT_BYTES - 1) / SLOT_BYTES;
  localparam int unsigned NUM_W = 9;
  localparam int unsigned RECIP_W = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W = NUM_W + RECIP_W;

  logic [NUM_W-1:0]  numer;
  logic [PROD_W-1:0] prod;

  assign numer = NUM_W'(req_i.payload.name_length) + NUM_W'(SLOT_BYTES - 1);
  assign prod  = PROD_W'(numer) * PROD_W'(RECIP);

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

  always_comb begin
    cmd_o.req  = req_i.payload.req_type;
    cmd_o.need = prod[RECIP_SHIFT +: 8];
    cmd_o.posn = req_i.payload.slot_position;
  end

endmodule

### rtl/idsa_cmd_fifo.sv
module idsa_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  idsa_pkg::cmd_t   wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output idsa_pkg::cmd_t   rd_data_o
);
  import idsa_pkg::*;

  localparam int unsigned PW = $clog2(CMD_FIFO_DEPTH);
  localparam int unsigned CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          mem_q [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign wr_ready_o = (count_q != CW'(CMD_FIFO_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = push ? PW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = CW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/idsa_back.sv
module idsa_back #(
  parameter int unsigned NUM_SLOTS = 182
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  idsa_pkg::cmd_t   cmd_i,
  idsa_stream_if.source    rsp_o
);
  import idsa_pkg::*;

  localparam int unsigned NW  = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned SW  = $clog2(NUM_SLOTS);
  localparam int unsigned LOW = (SW > 8) ? SW : 8;
  localparam int unsigned HW  = LOW + 1;

  idsa_state_e           state_q, state_d;
  logic [NW*WORD_BITS-1:0] bitmap_q;
  logic [WIW-1:0]        w_q, w_d;
  logic [7:0]            run_q, run_d;
  logic [SW-1:0]         start_q, start_d;
  logic [7:0]            need_eff_q, need_eff_d;
  logic                  set_q, set_d;
  logic [LOW-1:0]        lo_q, lo_d;
  logic [7:0]            cnt_q, cnt_d;
  logic                  any_q, any_d;
  logic                  status_q, status_d;
  logic [7:0]            granted_q, granted_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic [WORD_BITS-1:0]  cur_word;
  logic                  last_word;
  logic                  out_free;
  logic                  rsp_load;

  logic [7:0]            scan_run;
  logic [SW-1:0]         scan_start;
  logic                  scan_found;
  logic [WORD_BITS-1:0]  apply_word;
  logic                  apply_any;

  assign cur_word  = bitmap_q[w_q*WORD_BITS +: WORD_BITS];
  assign last_word = (w_q == WIW'(NW - 1));
  assign out_free  = !rsp_valid_q || rsp_o.ready;

  // First-fit walk over one word, carrying the current free run across words.
  always_comb begin
    logic [HW-1:0] base;
    logic [HW-1:0] slot;
    logic          is_free;
    base       = HW'(w_q) * HW'(WORD_BITS);
    scan_run   = run_q;
    scan_start = start_q;
    scan_found = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      slot    = base + HW'(j);
      is_free = !cur_word[j] && (slot < HW'(NUM_SLOTS));
      if (!scan_found) begin
        if (!is_free) begin
          scan_run = '0;
        end else begin
          if (scan_run == '0) begin
            scan_start = SW'(slot);
          end
          scan_run = 8'(scan_run + 1'b1);
          if (scan_run >= need_eff_q) begin
            scan_found = 1'b1;
          end
        end
      end
    end
  end

  // Set or clear the slots of [lo, lo + cnt) in this word; note any use from slot 2 up.
  always_comb begin
    logic [HW-1:0] base;
    logic [HW-1:0] hi;
    logic [HW-1:0] slot;
    logic          in_tbl;
    base      = HW'(w_q) * HW'(WORD_BITS);
    hi        = HW'(lo_q) + HW'(cnt_q);
    apply_any = 1'b0;
    for (int j = 0; j < WORD_BITS; j++) begin
      slot   = base + HW'(j);
      in_tbl = (slot < HW'(NUM_SLOTS));
      if (in_tbl && (slot >= HW'(lo_q)) && (slot < hi)) begin
        apply_word[j] = set_q;
      end else begin
        apply_word[j] = cur_word[j];
      end
      if (apply_word[j] && in_tbl && (slot >= HW'(DOT_SLOTS))) begin
        apply_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = (cmd_i.req == REQ_ALLOC) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (scan_found || last_word) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (last_word) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    rsp_load    = 1'b0;
    w_d         = w_q;
    run_d       = run_q;
    start_d     = start_q;
    need_eff_d  = need_eff_q;
    set_d       = set_q;
    lo_d        = lo_q;
    cnt_d       = cnt_q;
    any_d       = any_q;
    status_d    = status_q;
    granted_d   = granted_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          w_d        = '0;
          run_d      = '0;
          any_d      = 1'b0;
          status_d   = STATUS_OK;
          granted_d  = '0;
          // A zero-length entry still needs one free slot to be found.
          need_eff_d = (cmd_i.need == '0) ? 8'd1 : cmd_i.need;
          unique case (cmd_i.req)
            REQ_ALLOC: begin
              set_d = 1'b1;
              lo_d  = '0;
              cnt_d = cmd_i.need;
            end
            REQ_FREE: begin
              set_d = 1'b0;
              lo_d  = LOW'(cmd_i.posn);
              cnt_d = cmd_i.need;
            end
            REQ_INIT: begin
              set_d = 1'b1;
              lo_d  = '0;
              cnt_d = 8'(DOT_SLOTS);
            end
            default: begin
              set_d = 1'b0;
              lo_d  = '0;
              cnt_d = '0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        run_d   = scan_run;
        start_d = scan_start;
        if (scan_found) begin
          lo_d      = LOW'(scan_start);
          granted_d = 8'(scan_start);
          w_d       = '0;
        end else if (last_word) begin
          // No room: leave the bitmap alone, still walk it for the empty flag.
          status_d = STATUS_NO_ROOM;
          cnt_d    = '0;
          w_d      = '0;
        end else begin
          w_d = WIW'(w_q + 1'b1);
        end
      end
      ST_APPLY: begin
        any_d = any_q || apply_any;
        if (!last_word) begin
          w_d = WIW'(w_q + 1'b1);
        end
      end
      ST_DONE: begin
        rsp_load = out_free;
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d        = 1'b1;
      rsp_d.status       = status_q;
      rsp_d.granted_slot = granted_q;
      rsp_d.dir_empty    = !any_q;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
      bitmap_q    <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == ST_APPLY) begin
        bitmap_q[w_q*WORD_BITS +: WORD_BITS] <= apply_word;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    run_q      <= run_d;
    start_q    <= start_d;
    need_eff_q <= need_eff_d;
    set_q      <= set_d;
    lo_q       <= lo_d;
    cnt_q      <= cnt_d;
    any_q      <= any_d;
    status_q   <= status_d;
    granted_q  <= granted_d;
    rsp_q      <= rsp_d;
  end

endmodule

### rtl/inline_dentry_slot_allocator.sv
// Directory entry slot allocator: one result per request, in request order. Requests
// enter a two-entry command queue, so up to two can wait behind the one being served
// while a result waits for its transfer. The bitmap is walked one 8-slot word per
// cycle over W = ceil(NUM_SLOTS / 8) words (23 for 182 slots): an allocate first scans
// up to the word in which the first fitting run completes (all W on no room), then
// every request walks all W words to apply its change and set the empty flag. The
// bitmap is cleared by reset itself, so requests are taken from the first cycle
// after reset.
module inline_dentry_slot_allocator #(
  parameter int unsigned NUM_SLOTS  = 182,
  parameter int unsigned SLOT_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  idsa_stream_if.sink   req_i,
  idsa_stream_if.source rsp_o
);
  import idsa_pkg::*;

  logic cmd_in_valid, cmd_in_ready;
  cmd_t cmd_in;
  logic cmd_out_valid, cmd_out_ready;
  cmd_t cmd_out;

  idsa_front #(
    .SLOT_BYTES (SLOT_BYTES)
  ) u_front (
    .req_i       (req_i),
    .cmd_valid_o (cmd_in_valid),
    .cmd_o       (cmd_in),
    .cmd_ready_i (cmd_in_ready)
  );

  idsa_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_in_valid),
    .wr_ready_o (cmd_in_ready),
    .wr_data_i  (cmd_in),
    .rd_valid_o (cmd_out_valid),
    .rd_ready_i (cmd_out_ready),
    .rd_data_o  (cmd_out)
  );

  idsa_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_out_valid),
    .cmd_ready_o (cmd_out_ready),
    .cmd_i       (cmd_out),
    .rsp_o       (rsp_o)
  );

endmodule

### rtl/idsa_checker.sv
`include "assert_macros.svh"

module idsa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic       rsp_status_i,
  input logic [7:0] rsp_granted_slot_i,
  input logic       rsp_dir_empty_i
);
  import idsa_pkg::*;

  // Queue, engine and output register hold at most this many requests.
  localparam int unsigned MAX_OUTST = CMD_FIFO_DEPTH + 2;

  logic       req_fire, rsp_fire;
  logic [2:0] outst_q, outst_d;
  logic       rsp_stall, rsp_no_room;
  logic [9:0] rsp_word;

  assign req_fire    = req_valid_i && req_ready_i;
  assign rsp_fire    = rsp_valid_i && rsp_ready_i;
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign rsp_no_room = rsp_valid_i && (rsp_status_i == STATUS_NO_ROOM);
  assign rsp_word    = {rsp_status_i, rsp_granted_slot_i, rsp_dir_empty_i};

  always_comb begin
    outst_d = outst_q;
    if (req_fire && !rsp_fire) begin
      outst_d = 3'(outst_q + 1'b1);
    end else if (rsp_fire && !req_fire) begin
      outst_d = 3'(outst_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  `IDSA_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(rsp_word), "result not held")
  `IDSA_ASSERT_IMP(a_no_spurious_rsp, rsp_valid_i, outst_q != 3'd0, "result with no request")
  `IDSA_ASSERT_IMP(a_outst_bound, 1'b1, outst_q <= 3'(MAX_OUTST), "too many in flight")
  `IDSA_ASSERT_IMP(a_no_room_slot, rsp_no_room, rsp_granted_slot_i == 8'd0, "no-room slot set")

endmodule

bind inline_dentry_slot_allocator idsa_checker u_idsa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_status_i       (rsp_o.payload.status),
  .rsp_granted_slot_i (rsp_o.payload.granted_slot),
  .rsp_dir_empty_i    (rsp_o.payload.dir_empty)
);

### dv/idsa_slot_checker.sv
`timescale 1ns / 100ps

module idsa_slot_checker #(
  parameter int unsigned NUM_SLOTS  = 182,
  parameter int unsigned SLOT_BYTES = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  idsa_pkg::req_t  req_payload_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  idsa_pkg::rsp_t  rsp_payload_i,
  output int unsigned     fail_cnt_o,
  output int unsigned     pending_o
);
  import idsa_pkg::*;

  logic [NUM_SLOTS-1:0] slot_map;
  rsp_t                 awaited_rsps[$];
  int unsigned          fail_cnt = 0;

  // Lowest start of a free run of at least need slots; NUM_SLOTS when none fits.
  function automatic int unsigned first_fit(input int unsigned need);
    int unsigned run_len;
    int unsigned run_start;
    run_len   = 0;
    run_start = 0;
    for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
      if (slot_map[i]) begin
        run_len = 0;
      end else begin
        if (run_len == 0) run_start = i;
        run_len++;
        if (run_len >= need) return run_start;
      end
    end
    return NUM_SLOTS;
  endfunction

  function automatic rsp_t apply_dentry_op(input req_t op);
    rsp_t        rsp;
    int unsigned need;
    int unsigned start;
    need             = (32'(op.name_length) + SLOT_BYTES - 1) / SLOT_BYTES;
    rsp.status       = STATUS_OK;
    rsp.granted_slot = '0;
    case (op.req_type)
      REQ_ALLOC: begin
        start = first_fit(need);
        if (start >= NUM_SLOTS) begin
          rsp.status = STATUS_NO_ROOM;
        end else begin
          for (int unsigned i = 0; i < need && start + i < NUM_SLOTS; i++)
            slot_map[start + i] = 1'b1;
          rsp.granted_slot = 8'(start);
        end
      end
      REQ_FREE: begin
        // Clip at the table end; no check that the slots were in use.
        for (int unsigned i = 0; i < need && op.slot_position + i < NUM_SLOTS; i++)
          slot_map[op.slot_position + i] = 1'b0;
      end
      REQ_INIT: begin
        for (int unsigned i = 0; i < DOT_SLOTS; i++) slot_map[i] = 1'b1;
      end
      default: ;
    endcase
    rsp.dir_empty = ~|(slot_map >> DOT_SLOTS);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      slot_map = '0;
      awaited_rsps.delete();
    end else begin
      // Retire the response before logging a new request: it can only be older.
      if (rsp_valid_i && rsp_ready_i) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, got status %0b slot %0d empty %0b",
                   $time, rsp_payload_i.status, rsp_payload_i.granted_slot,
                   rsp_payload_i.dir_empty);
          fail_cnt++;
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_payload_i.status !== want.status) begin
            $display("%0t: status expected %0b, got %0b",
                     $time, want.status, rsp_payload_i.status);
            fail_cnt++;
          end
          if (rsp_payload_i.granted_slot !== want.granted_slot) begin
            $display("%0t: granted_slot expected %0d, got %0d",
                     $time, want.granted_slot, rsp_payload_i.granted_slot);
            fail_cnt++;
          end
          if (rsp_payload_i.dir_empty !== want.dir_empty) begin
            $display("%0t: dir_empty expected %0b, got %0b",
                     $time, want.dir_empty, rsp_payload_i.dir_empty);
            fail_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) awaited_rsps.push_back(apply_dentry_op(req_payload_i));
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= awaited_rsps.size();
  end

endmodule

### dv/inline_dentry_slot_allocator_tb.sv
`timescale 1ns / 100ps

module inline_dentry_slot_allocator_tb;
  import idsa_pkg::*;

  localparam int unsigned NUM_SLOTS    = 182;
  localparam int unsigned SLOT_BYTES   = 8;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned IDLE_PCT     = 9;
  // Sender keeps valid up without gaps over this span of random items.
  localparam int unsigned GAPLESS_FROM = 300;
  localparam int unsigned GAPLESS_TO   = 450;
  // Receiver cycle windows: one long hold-off, one stretch with no stalls.
  localparam int unsigned HOLD_AT      = 4000;
  localparam int unsigned HOLD_LEN     = 400;
  localparam int unsigned STEADY_FROM  = 20000;
  localparam int unsigned STEADY_TO    = 26000;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_CHURN
  } op_mix_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_cnt;
  int unsigned pending;

  idsa_stream_if #(.payload_t(req_t)) req_if ();
  idsa_stream_if #(.payload_t(rsp_t)) rsp_if ();

  inline_dentry_slot_allocator #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  idsa_slot_checker #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_payload_i(req_if.payload),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_payload_i(rsp_if.payload),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Offer one request and hold it until the transfer.
  task automatic send_dentry_op(input idsa_req_e kind, input logic [7:0] len,
                                input logic [7:0] posn, input bit may_idle);
    req_t op;
    op = '{req_type: kind, name_length: len, slot_position: posn};
    if (may_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= op;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // Mostly short names; a few empty ones and a tail up to the longest.
  function automatic logic [7:0] pick_name_length();
    int unsigned d;
    d = $urandom_range(99);
    if (d < 4) return 8'd0;
    if (d < 75) return 8'($urandom_range(1, 40));
    if (d < 90) return 8'($urandom_range(41, 128));
    return 8'($urandom_range(129, 255));
  endfunction

  task automatic send_random_op(input op_mix_e mix, input bit may_idle);
    int unsigned d;
    int unsigned alloc_pct;
    int unsigned free_pct;
    idsa_req_e   kind;
    logic [7:0]  posn;
    case (mix)
      MIX_FILL:  begin alloc_pct = 75; free_pct = 15; end
      MIX_DRAIN: begin alloc_pct = 20; free_pct = 70; end
      default:   begin alloc_pct = 45; free_pct = 40; end
    endcase
    d = $urandom_range(99);
    if (d < alloc_pct) kind = REQ_ALLOC;
    else if (d < alloc_pct + free_pct) kind = REQ_FREE;
    else if (d < alloc_pct + free_pct + 5) kind = REQ_QUERY;
    else kind = REQ_INIT;
    // Most frees land inside the table; some start past its end.
    if ($urandom_range(99) < 10) posn = 8'($urandom_range(NUM_SLOTS, 255));
    else posn = 8'($urandom_range(0, NUM_SLOTS - 1));
    send_dentry_op(kind, pick_name_length(), posn, may_idle);
  endtask

  initial begin
    int unsigned sent;
    int unsigned span;
    op_mix_e     mix;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_dentry_op(REQ_QUERY, 8'd0, 8'd0, 1'b1);
    send_dentry_op(REQ_ALLOC, 8'd0, 8'd0, 1'b1);     // empty name on an empty table
    send_dentry_op(REQ_INIT,  8'd0, 8'd0, 1'b1);
    send_dentry_op(REQ_INIT,  8'd5, 8'd9, 1'b1);     // dot entries already present
    send_dentry_op(REQ_ALLOC, 8'd1, 8'd0, 1'b1);
    send_dentry_op(REQ_ALLOC, 8'd8, 8'd0, 1'b1);
    send_dentry_op(REQ_ALLOC, 8'd9, 8'd0, 1'b1);
    send_dentry_op(REQ_FREE,  8'd8, 8'd3, 1'b1);     // leave a one-slot hole
    send_dentry_op(REQ_ALLOC, 8'd255, 8'd0, 1'b1);   // must skip the hole
    send_dentry_op(REQ_FREE,  8'd1, 8'd3, 1'b1);     // slot already clear
    send_dentry_op(REQ_FREE,  8'd255, 8'd181, 1'b1); // clipped at the end
    send_dentry_op(REQ_FREE,  8'd255, 8'd182, 1'b1); // wholly past the end
    send_dentry_op(REQ_FREE,  8'd255, 8'd255, 1'b1);
    send_dentry_op(REQ_QUERY, 8'd255, 8'd255, 1'b1);
    repeat (5) send_dentry_op(REQ_ALLOC, 8'd255, 8'd0, 1'b1);  // last one finds no room
    send_dentry_op(REQ_ALLOC, 8'd128, 8'd0, 1'b1);
    send_dentry_op(REQ_ALLOC, 8'd1, 8'd0, 1'b1);     // fills the table
    send_dentry_op(REQ_ALLOC, 8'd0, 8'd0, 1'b1);     // empty name, no free slot
    send_dentry_op(REQ_FREE,  8'd255, 8'd0, 1'b1);
    send_dentry_op(REQ_FREE,  8'd0, 8'd40, 1'b1);    // zero slots to clear
    send_dentry_op(REQ_QUERY, 8'd0, 8'd0, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mix  = op_mix_e'($urandom_range(0, 2));
      span = $urandom_range(20, 80);
      repeat (span) begin
        if (sent < RANDOM_ITEMS) begin
          send_random_op(mix, !(sent >= GAPLESS_FROM && sent < GAPLESS_TO));
          sent++;
        end
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the block, one steady stretch.
  initial begin
    int unsigned cyc;
    cyc = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc >= HOLD_AT && cyc < HOLD_AT + HOLD_LEN) begin
        rsp_if.ready <= 1'b0;
      end else if (cyc >= STEADY_FROM && cyc < STEADY_TO) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
